>>> rtl/shsc_pkg.sv
// ----------------------------------------------------------------------------
// Steering stepper controller package
// Shared codes, calibration mode type and default widths.
// ----------------------------------------------------------------------------
`default_nettype none

package shsc_pkg;

   localparam int POS_WIDTH_DEF = 16;
   localparam int TARGET_WIDTH  = 16;
   localparam int PHASE_WIDTH   = 4;

   localparam logic ACT_TICK       = 1'b0;
   localparam logic ACT_SET_TARGET = 1'b1;

   typedef enum logic [1:0] {
      MODE_SWEEP_RIGHT = 2'd0,
      MODE_SWEEP_LEFT  = 2'd1,
      MODE_COUNT_RIGHT = 2'd2,
      MODE_READY       = 2'd3
   } mode_type;

endpackage

`default_nettype wire

>>> rtl/stepper_homing_steer_controller.sv
// ----------------------------------------------------------------------------
// Steering stepper homing and position tracking
// Sweeps to both limit switches, targets the midpoint, then tracks a target.
// ----------------------------------------------------------------------------
//   channel  direction  payload
//   req_     in         action, new_target, left_limit, right_limit
//   rsp_     out        coil_phase, current_position, left_end, right_end,
//                       target_position, ready_res
//
// One request per cycle while req_ready is high: state registers update on
// acceptance; the response appears in the result register on the next cycle.
// req_ready stays high while the result register is empty or being taken,
// so a stalled response stops only the request that would overwrite it.
// Synchronous reset returns to the first right sweep with all positions zero.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_homing_steer_controller
   import shsc_pkg::*;
#(
   parameter int POS_WIDTH = POS_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_action,
   input  logic signed [TARGET_WIDTH-1:0] req_new_target,
   input  logic                          req_left_limit,
   input  logic                          req_right_limit,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [PHASE_WIDTH-1:0]        rsp_coil_phase,
   output logic signed [POS_WIDTH-1:0]   rsp_current_position,
   output logic signed [POS_WIDTH-1:0]   rsp_left_end,
   output logic signed [POS_WIDTH-1:0]   rsp_right_end,
   output logic signed [POS_WIDTH-1:0]   rsp_target_position,
   output logic                          rsp_ready_res
);

   mode_type                    mode_ff, mode_in;
   logic signed [POS_WIDTH-1:0] position_ff, position_in;
   logic signed [POS_WIDTH-1:0] left_stop_ff, left_stop_in;
   logic signed [POS_WIDTH-1:0] right_stop_ff, right_stop_in;
   logic signed [POS_WIDTH-1:0] goal_ff, goal_in;
   logic                        accept;
   logic [PHASE_WIDTH-1:0]      phase_next;

   assign accept = req_valid && req_ready;

   shsc_step #(.POS_WIDTH(POS_WIDTH)) u_step (
      .mode_ff       (mode_ff),
      .position_ff   (position_ff),
      .left_stop_ff  (left_stop_ff),
      .right_stop_ff (right_stop_ff),
      .goal_ff       (goal_ff),
      .action        (req_action),
      .new_target    (req_new_target),
      .left_limit    (req_left_limit),
      .right_limit   (req_right_limit),
      .mode_in       (mode_in),
      .position_in   (position_in),
      .left_stop_in  (left_stop_in),
      .right_stop_in (right_stop_in),
      .goal_in       (goal_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_SWEEP_RIGHT;
         position_ff   <= '0;
         left_stop_ff  <= '0;
         right_stop_ff <= '0;
         goal_ff       <= '0;
      end else if (accept) begin
         mode_ff       <= mode_in;
         position_ff   <= position_in;
         left_stop_ff  <= left_stop_in;
         right_stop_ff <= right_stop_in;
         goal_ff       <= goal_in;
      end
   end

   // wave drive: one coil per position mod 4
   assign phase_next = PHASE_WIDTH'(1) << position_in[1:0];

   shsc_out_reg #(.POS_WIDTH(POS_WIDTH)) u_out (
      .clock                (clock),
      .reset                (reset),
      .load                 (accept),
      .load_ready           (req_ready),
      .coil_phase_in        (phase_next),
      .position_in          (position_in),
      .left_end_in          (left_stop_in),
      .right_end_in         (right_stop_in),
      .target_in            (goal_in),
      .ready_res_in         (mode_in == MODE_READY),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_coil_phase       (rsp_coil_phase),
      .rsp_current_position (rsp_current_position),
      .rsp_left_end         (rsp_left_end),
      .rsp_right_end        (rsp_right_end),
      .rsp_target_position  (rsp_target_position),
      .rsp_ready_res        (rsp_ready_res)
   );

   // pending response mirrors the state it was computed from
   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_current_position == position_ff)
                    && (rsp_ready_res == (mode_ff == MODE_READY)))
      else $error("pending response does not match state registers");

   a_single_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (position_ff == $past(position_ff))
               || (position_ff == $past(position_ff) + POS_WIDTH'(1))
               || (position_ff == $past(position_ff) - POS_WIDTH'(1)))
      else $error("position moved by more than one step");

   a_ready_sticky: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_READY) |=> (mode_ff == MODE_READY))
      else $error("left tracking mode without reset");

   a_accept_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty result register");

endmodule

`default_nettype wire

>>> rtl/shsc_step.sv
// ----------------------------------------------------------------------------
// Steering stepper step logic
// Next calibration mode, position, end stops and target for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module shsc_step
   import shsc_pkg::*;
#(
   parameter int POS_WIDTH = POS_WIDTH_DEF
) (
   input  mode_type                      mode_ff,
   input  logic signed [POS_WIDTH-1:0]   position_ff,
   input  logic signed [POS_WIDTH-1:0]   left_stop_ff,
   input  logic signed [POS_WIDTH-1:0]   right_stop_ff,
   input  logic signed [POS_WIDTH-1:0]   goal_ff,
   input  logic                          action,
   input  logic signed [TARGET_WIDTH-1:0] new_target,
   input  logic                          left_limit,
   input  logic                          right_limit,
   output mode_type                      mode_in,
   output logic signed [POS_WIDTH-1:0]   position_in,
   output logic signed [POS_WIDTH-1:0]   left_stop_in,
   output logic signed [POS_WIDTH-1:0]   right_stop_in,
   output logic signed [POS_WIDTH-1:0]   goal_in
);

   localparam int EXT_W = ((POS_WIDTH > TARGET_WIDTH) ? POS_WIDTH : TARGET_WIDTH) + 1;
   localparam logic signed [EXT_W-1:0] P_MAX =
      (EXT_W'(1) << (POS_WIDTH - 1)) - EXT_W'(1);
   localparam logic signed [EXT_W-1:0] P_MIN = -P_MAX - EXT_W'(1);

   logic signed [EXT_W-1:0]     target_ext;
   logic signed [POS_WIDTH-1:0] target_sat;
   logic                        at_max;
   logic                        at_min;
   logic signed [POS_WIDTH-1:0] pos_up;
   logic signed [POS_WIDTH-1:0] pos_down;
   logic signed [POS_WIDTH:0]   end_sum;
   logic signed [POS_WIDTH:0]   end_adj;
   logic signed [POS_WIDTH-1:0] midpoint;

   assign target_ext = {{(EXT_W - TARGET_WIDTH){new_target[TARGET_WIDTH-1]}}, new_target};

   always_comb begin
      if (target_ext > P_MAX) begin
         target_sat = P_MAX[POS_WIDTH-1:0];
      end else if (target_ext < P_MIN) begin
         target_sat = P_MIN[POS_WIDTH-1:0];
      end else begin
         target_sat = target_ext[POS_WIDTH-1:0];
      end
   end

   // hold at the range ends instead of wrapping
   assign at_max   = (position_ff == {1'b0, {(POS_WIDTH-1){1'b1}}});
   assign at_min   = (position_ff == {1'b1, {(POS_WIDTH-1){1'b0}}});
   assign pos_up   = at_max ? position_ff : position_ff + POS_WIDTH'(1);
   assign pos_down = at_min ? position_ff : position_ff - POS_WIDTH'(1);

   // midpoint rounded toward zero: bias negative sums by one before the shift
   assign end_sum  = {left_stop_ff[POS_WIDTH-1], left_stop_ff}
                   + {position_ff[POS_WIDTH-1], position_ff};
   assign end_adj  = end_sum + {{POS_WIDTH{1'b0}}, end_sum[POS_WIDTH]};
   assign midpoint = end_adj[POS_WIDTH:1];

   always_comb begin
      mode_in       = mode_ff;
      position_in   = position_ff;
      left_stop_in  = left_stop_ff;
      right_stop_in = right_stop_ff;
      goal_in       = goal_ff;
      if (action == ACT_SET_TARGET) begin
         goal_in = target_sat;
      end else begin
         case (mode_ff)
            MODE_SWEEP_RIGHT: begin
               if (right_limit) mode_in = MODE_SWEEP_LEFT;
               else             position_in = pos_up;
            end
            MODE_SWEEP_LEFT: begin
               if (left_limit) begin
                  left_stop_in = position_ff;
                  mode_in      = MODE_COUNT_RIGHT;
               end else begin
                  position_in = pos_down;
               end
            end
            MODE_COUNT_RIGHT: begin
               if (right_limit) begin
                  right_stop_in = position_ff;
                  goal_in       = midpoint;
                  mode_in       = MODE_READY;
               end else begin
                  position_in = pos_up;
               end
            end
            default: begin
               if (position_ff < goal_ff)      position_in = pos_up;
               else if (position_ff > goal_ff) position_in = pos_down;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

>>> rtl/shsc_out_reg.sv
// ----------------------------------------------------------------------------
// Steering stepper result register
// Holds one response and frees itself for the next request as it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module shsc_out_reg
   import shsc_pkg::*;
#(
   parameter int POS_WIDTH = POS_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   output logic                        load_ready,
   input  logic [PHASE_WIDTH-1:0]      coil_phase_in,
   input  logic signed [POS_WIDTH-1:0] position_in,
   input  logic signed [POS_WIDTH-1:0] left_end_in,
   input  logic signed [POS_WIDTH-1:0] right_end_in,
   input  logic signed [POS_WIDTH-1:0] target_in,
   input  logic                        ready_res_in,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [PHASE_WIDTH-1:0]      rsp_coil_phase,
   output logic signed [POS_WIDTH-1:0] rsp_current_position,
   output logic signed [POS_WIDTH-1:0] rsp_left_end,
   output logic signed [POS_WIDTH-1:0] rsp_right_end,
   output logic signed [POS_WIDTH-1:0] rsp_target_position,
   output logic                        rsp_ready_res
);

   logic valid_ff;
   logic valid_in;

   assign load_ready = !valid_ff || rsp_ready;
   assign valid_in   = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_coil_phase       <= coil_phase_in;
         rsp_current_position <= position_in;
         rsp_left_end         <= left_end_in;
         rsp_right_end        <= right_end_in;
         rsp_target_position  <= target_in;
         rsp_ready_res        <= ready_res_in;
      end
   end

   assign rsp_valid = valid_ff;

endmodule

`default_nettype wire

>>> sim/shsc_response_checker.sv
// ----------------------------------------------------------------------------
// Steering controller response checker
// Watches both channels and predicts the drive word for every accepted
// request. Compares each response with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module shsc_response_checker
   import shsc_pkg::*;
#(
   parameter int POS_WIDTH = POS_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic                           req_action,
   input  logic signed [TARGET_WIDTH-1:0] req_new_target,
   input  logic                           req_left_limit,
   input  logic                           req_right_limit,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [PHASE_WIDTH-1:0]         rsp_coil_phase,
   input  logic signed [POS_WIDTH-1:0]    rsp_current_position,
   input  logic signed [POS_WIDTH-1:0]    rsp_left_end,
   input  logic signed [POS_WIDTH-1:0]    rsp_right_end,
   input  logic signed [POS_WIDTH-1:0]    rsp_target_position,
   input  logic                           rsp_ready_res,
   output int                             fail_count,
   output int                             pending_count,
   output int                             checked_count
);

   localparam longint POS_HI = (longint'(1) <<< (POS_WIDTH - 1)) - 1;
   localparam longint POS_LO = -(longint'(1) <<< (POS_WIDTH - 1));

   typedef struct {
      logic [PHASE_WIDTH-1:0]      coil;
      logic signed [POS_WIDTH-1:0] pos;
      logic signed [POS_WIDTH-1:0] left;
      logic signed [POS_WIDTH-1:0] right;
      logic signed [POS_WIDTH-1:0] goal;
      logic                        ready;
   } drive_word_type;

   drive_word_type pending_drives[$];

   mode_type steer_mode;
   longint   shaft_pos;
   longint   left_stop;
   longint   right_stop;
   longint   goal_pos;
   int       fails;
   int       checked;

   function automatic longint clamp_pos(input longint v);
      if (v > POS_HI) begin
         return POS_HI;
      end
      if (v < POS_LO) begin
         return POS_LO;
      end
      return v;
   endfunction

   // Advance the calibration / tracking state by one request and form its drive word.
   function automatic drive_word_type predict_drive(input logic act, input longint aim,
                                                    input logic left_hit,
                                                    input logic right_hit);
      drive_word_type w;
      if (act == ACT_SET_TARGET) begin
         goal_pos = clamp_pos(aim);
      end else begin
         case (steer_mode)
            MODE_SWEEP_RIGHT: begin
               if (right_hit) steer_mode = MODE_SWEEP_LEFT;
               else shaft_pos = clamp_pos(shaft_pos + 1);
            end
            MODE_SWEEP_LEFT: begin
               if (left_hit) begin
                  left_stop  = shaft_pos;
                  steer_mode = MODE_COUNT_RIGHT;
               end else begin
                  shaft_pos = clamp_pos(shaft_pos - 1);
               end
            end
            MODE_COUNT_RIGHT: begin
               if (right_hit) begin
                  right_stop = shaft_pos;
                  steer_mode = MODE_READY;
                  // integer division truncates toward zero
                  goal_pos   = (left_stop + right_stop) / 2;
               end else begin
                  shaft_pos = clamp_pos(shaft_pos + 1);
               end
            end
            default: begin
               if (shaft_pos < goal_pos) shaft_pos = clamp_pos(shaft_pos + 1);
               else if (shaft_pos > goal_pos) shaft_pos = clamp_pos(shaft_pos - 1);
            end
         endcase
      end
      w.coil  = PHASE_WIDTH'(1) << shaft_pos[1:0];
      w.pos   = POS_WIDTH'(shaft_pos);
      w.left  = POS_WIDTH'(left_stop);
      w.right = POS_WIDTH'(right_stop);
      w.goal  = POS_WIDTH'(goal_pos);
      w.ready = (steer_mode == MODE_READY);
      return w;
   endfunction

   always @(posedge clock) begin : watch
      drive_word_type want;
      if (reset) begin
         pending_drives.delete();
         steer_mode = MODE_SWEEP_RIGHT;
         shaft_pos  = 0;
         left_stop  = 0;
         right_stop = 0;
         goal_pos   = 0;
      end else begin
         // retire the response first: it always belongs to an earlier request
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (pending_drives.size() == 0) begin
               fails++;
               if (fails <= 10) begin
                  $display("unexpected response: pos=%0d target=%0d ready=%b",
                           rsp_current_position, rsp_target_position, rsp_ready_res);
               end
            end else begin
               want = pending_drives.pop_front();
               if (rsp_coil_phase !== want.coil || rsp_current_position !== want.pos ||
                   rsp_left_end !== want.left || rsp_right_end !== want.right ||
                   rsp_target_position !== want.goal || rsp_ready_res !== want.ready) begin
                  fails++;
                  if (fails <= 10) begin
                     $display("mismatch on response %0d:", checked);
                     $display("  exp coil=%b pos=%0d left=%0d right=%0d target=%0d ready=%b",
                              want.coil, want.pos, want.left, want.right, want.goal,
                              want.ready);
                     $display("  got coil=%b pos=%0d left=%0d right=%0d target=%0d ready=%b",
                              rsp_coil_phase, rsp_current_position, rsp_left_end,
                              rsp_right_end, rsp_target_position, rsp_ready_res);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            pending_drives.push_back(predict_drive(req_action, longint'(req_new_target),
                                                   req_left_limit, req_right_limit));
         end
      end
      fail_count    <= fails;
      pending_count <= pending_drives.size();
      checked_count <= checked;
   end

endmodule

`default_nettype wire

>>> sim/stepper_homing_steer_controller_tb.sv
// ----------------------------------------------------------------------------
// Steering stepper controller testbench
// Drives a few directed requests, then short calibration sweeps that end on
// an odd negative sum of the ends, then random target tracking under mixed
// flow control. Checking is done by the response checker beside the block.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_homing_steer_controller_tb;
   import shsc_pkg::*;

   localparam int          POS_W        = POS_WIDTH_DEF;
   localparam int unsigned CYCLE_LIMIT  = 3_000_000;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          ROTATE_EVERY = 128;
   localparam int          TRACK_BLOCK  = 160;

   typedef enum int {
      FLOW_FREE,
      FLOW_SENDER_GAPS,
      FLOW_RECEIVER_STALLS,
      FLOW_BOTH
   } flow_mix_type;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic                           req_action;
   logic signed [TARGET_WIDTH-1:0] req_new_target;
   logic                           req_left_limit;
   logic                           req_right_limit;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [PHASE_WIDTH-1:0]         rsp_coil_phase;
   logic signed [POS_W-1:0]        rsp_current_position;
   logic signed [POS_W-1:0]        rsp_left_end;
   logic signed [POS_W-1:0]        rsp_right_end;
   logic signed [POS_W-1:0]        rsp_target_position;
   logic                           rsp_ready_res;

   int           fail_count;
   int           pending_count;
   int           checked_count;
   flow_mix_type flow = FLOW_FREE;
   int           hold_asks;
   int           holds_done;
   int           directed_requests;
   int           sweep_requests;
   int           track_requests;
   int unsigned  cycle_count;

   stepper_homing_steer_controller #(.POS_WIDTH(POS_W)) DUT (.*);

   shsc_response_checker #(.POS_WIDTH(POS_W)) steer_check (.*);

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Response side: random stalls per flow mix, plus one long hold on request.
   always begin
      @(negedge clock);
      if (holds_done < hold_asks) begin
         rsp_ready <= 1'b0;
         repeat (HOLD_CYCLES) @(negedge clock);
         holds_done++;
      end
      rsp_ready <= !((flow == FLOW_RECEIVER_STALLS || flow == FLOW_BOTH) &&
                     $urandom_range(0, 99) < 64);
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, pending_count);
      $display("== FAIL ==");
      $finish;
   end

   // Offer one request; returns at the edge that accepts it.
   task automatic send_request(input logic act, input logic [TARGET_WIDTH-1:0] aim,
                               input logic left_hit, input logic right_hit);
      @(negedge clock);
      while ((flow == FLOW_SENDER_GAPS || flow == FLOW_BOTH) &&
             $urandom_range(0, 99) < 64) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_new_target  <= aim;
      req_left_limit  <= left_hit;
      req_right_limit <= right_hit;
      do @(posedge clock); while (!req_ready);
   endtask

   // Step the motor a given number of times toward one switch, then close it.
   task automatic sweep(input int steps, input bit leftward);
      int   moved;
      logic other;
      moved = 0;
      other = 1'b0;
      while (moved < steps) begin
         other = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) == 0) begin
            send_request(ACT_SET_TARGET, TARGET_WIDTH'($urandom),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else begin
            if (leftward) send_request(ACT_TICK, TARGET_WIDTH'($urandom), 1'b0, other);
            else send_request(ACT_TICK, TARGET_WIDTH'($urandom), other, 1'b0);
            moved++;
         end
         sweep_requests++;
         if (sweep_requests % ROTATE_EVERY == 0) begin
            flow = flow_mix_type'((int'(flow) + 1) % 4);
         end
      end
      other = 1'($urandom_range(0, 1));
      if (leftward) send_request(ACT_TICK, TARGET_WIDTH'($urandom), 1'b1, other);
      else send_request(ACT_TICK, TARGET_WIDTH'($urandom), other, 1'b1);
      sweep_requests++;
   endtask

   initial begin
      int count_steps;
      int left_pos;
      int mid;
      int aim;
      int pick;
      int block_start;
      int run_len;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_action      = ACT_TICK;
      req_new_target  = '0;
      req_left_limit  = 1'b0;
      req_right_limit = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Targets written during the first sweep are held, then replaced by the midpoint.
      send_request(ACT_SET_TARGET, 16'h8000, 1'b0, 1'b0);
      send_request(ACT_SET_TARGET, 16'h7FFF, 1'b1, 1'b1);
      send_request(ACT_SET_TARGET, 16'h5555, 1'b1, 1'b0);
      send_request(ACT_SET_TARGET, 16'hAAAA, 1'b0, 1'b1);
      // left switch means nothing while sweeping right; walk all four coil phases
      send_request(ACT_TICK, 16'hFFFF, 1'b1, 1'b0);
      send_request(ACT_TICK, 16'h0000, 1'b0, 1'b0);
      send_request(ACT_TICK, 16'h1234, 1'b1, 1'b0);
      send_request(ACT_TICK, 16'h0000, 1'b0, 1'b0);
      send_request(ACT_TICK, 16'hFFFF, 1'b1, 1'b0);
      send_request(ACT_SET_TARGET, 16'h0000, 1'b0, 1'b0);
      send_request(ACT_SET_TARGET, 16'hFFFF, 1'b0, 1'b0);
      directed_requests = 11;

      // Sweep left past zero, then end on an odd negative sum so the
      // midpoint has to truncate toward zero.
      sweep(60, 1'b0);
      sweep(260, 1'b1);
      left_pos    = 5 + 60 - 260;
      count_steps = 2 * $urandom_range(20, 60) + 1;
      sweep(count_steps, 1'b0);
      mid = (2 * left_pos + count_steps) / 2;

      for (int blk = 0; blk < 4; blk++) begin
         flow = flow_mix_type'(blk);
         if (blk == 0) begin
            hold_asks++;
         end
         block_start = track_requests;
         while (track_requests - block_start < TRACK_BLOCK) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
               aim = mid + int'($urandom_range(0, 80)) - 40;
            end else if (pick == 7) begin
               case ($urandom_range(0, 2))
                  0:       aim = -32768;
                  1:       aim = 32767;
                  default: aim = 0;
               endcase
            end else begin
               aim = int'($urandom_range(0, 65535)) - 32768;
            end
            send_request(ACT_SET_TARGET, TARGET_WIDTH'(aim),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            track_requests++;
            run_len = $urandom_range(1, 60);
            repeat (run_len) begin
               send_request(ACT_TICK, TARGET_WIDTH'($urandom),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
               track_requests++;
            end
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("requests: %0d directed, %0d calibration (odd negative midpoint), %0d tracking",
               directed_requests, sweep_requests, track_requests);
      $display("%0d responses checked across four flow mixes and a %0d-cycle response hold",
               checked_count, HOLD_CYCLES);
      if (fail_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> sim.f
rtl/shsc_pkg.sv
rtl/shsc_step.sv
rtl/shsc_out_reg.sv
rtl/stepper_homing_steer_controller.sv
sim/shsc_response_checker.sv
sim/stepper_homing_steer_controller_tb.sv
